// File: src/lscc_pkg.sv
// ----------------------------------------------------------------------------
// lscc_pkg: LCG keystream cipher constants and tables
// Generator and checksum constants, register indexes, digit tables for the
// constant-modulus multiply steps and the final range reductions.
// ----------------------------------------------------------------------------
package lscc_pkg;

  localparam int BYTE_W   = 8;
  localparam int SEED_W   = 20;
  localparam int CK_W     = 23;
  localparam int DIG_W    = 5;
  localparam int DIG_N    = 1 << DIG_W;
  localparam int KS_DIGITS = 4;   // 20-bit generator value in 5-bit digits
  localparam int CK_DIGITS = 5;   // 23-bit checksum in 5-bit digits
  localparam int KS_SUM_W = 23;   // holds below 5 * KS_MOD
  localparam int CK_SUM_W = 26;   // holds below 6 * CK_MOD

  localparam longint unsigned KS_MULT   = 2399;
  localparam longint unsigned KS_OFFSET = 667818;
  localparam longint unsigned KS_MOD    = 894871;
  localparam longint unsigned CK_INIT   = 1232531;
  localparam longint unsigned CK_MOD    = 6506347;

  localparam int KS_FOLDS = 4;    // KS_SUM_W value < 5 * KS_MOD
  localparam int CK_FOLDS = 5;    // CK_SUM_W value < 6 * CK_MOD

  typedef enum logic {
    CFG_SEED_START   = 1'b0,
    CFG_DECRYPT_MODE = 1'b1
  } cfg_idx_t;

  typedef logic [KS_DIGITS-1:0][DIG_N-1:0][SEED_W-1:0] ks_tab_t;
  typedef logic [CK_DIGITS-1:0][DIG_N-1:0][CK_W-1:0]   ck_tab_t;

  // entry [k][d] = (d * 2^(5k) * KS_MULT) mod KS_MOD
  function automatic ks_tab_t ks_tab_gen();
    ks_tab_t t;
    longint unsigned v;
    for (int k = 0; k < KS_DIGITS; k++) begin
      for (int d = 0; d < DIG_N; d++) begin
        v = (64'(d) << (DIG_W * k)) * KS_MULT;
        t[k][d] = SEED_W'(v % KS_MOD);
      end
    end
    return t;
  endfunction

  // entry [k][d] = (d * 2^(5k) * 256) mod CK_MOD
  function automatic ck_tab_t ck_tab_gen();
    ck_tab_t t;
    longint unsigned v;
    for (int k = 0; k < CK_DIGITS; k++) begin
      for (int d = 0; d < DIG_N; d++) begin
        v = 64'(d) << (DIG_W * k + BYTE_W);
        t[k][d] = CK_W'(v % CK_MOD);
      end
    end
    return t;
  endfunction

  localparam ks_tab_t KS_TAB = ks_tab_gen();
  localparam ck_tab_t CK_TAB = ck_tab_gen();

  // parallel compares against multiples of the modulus, largest hit wins
  function automatic logic [SEED_W-1:0] ks_reduce(input logic [KS_SUM_W-1:0] v);
    logic [KS_SUM_W-1:0] r;
    r = v;
    for (int k = 1; k <= KS_FOLDS; k++) begin
      if (v >= KS_SUM_W'(64'(k) * KS_MOD)) begin
        r = v - KS_SUM_W'(64'(k) * KS_MOD);
      end
    end
    return r[SEED_W-1:0];
  endfunction

  function automatic logic [CK_W-1:0] ck_reduce(input logic [CK_SUM_W-1:0] v);
    logic [CK_SUM_W-1:0] r;
    r = v;
    for (int k = 1; k <= CK_FOLDS; k++) begin
      if (v >= CK_SUM_W'(64'(k) * CK_MOD)) begin
        r = v - CK_SUM_W'(64'(k) * CK_MOD);
      end
    end
    return r[CK_W-1:0];
  endfunction

endpackage

// File: src/lcg_stream_cipher_checksum.sv
// An accepted request passes through the input register and then the result register,
//   which drives out_valid.
// Throughput: one request per cycle while out_ready holds; the generator and checksum
//   update is combinational from the input register into the state and result registers.
// While a result waits the input register still takes one request; in_ready drops once both
//   registers hold requests. Reset (rst_n low, synchronous): generator 0, checksum 1232531,
//   both config registers 0, both stages empty.
// ----------------------------------------------------------------------------
// lcg_stream_cipher_checksum: LCG keystream XOR cipher with running checksum
// Byte-serial cipher. Each byte steps seed = (seed*2399 + 667818) mod 894871
// and is XORed with seed[17:10]; a checksum ((sum<<8)+b) mod 6506347 runs
// over the clear text and is checked on the last byte when decrypting.
// ----------------------------------------------------------------------------
module lcg_stream_cipher_checksum (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration writes
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [lscc_pkg::SEED_W-1:0]  cfg_wdata,
  // input requests
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lscc_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                         in_first,
  input  logic                         in_last,
  input  logic [lscc_pkg::CK_W-1:0]    in_expected_checksum,
  // results
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lscc_pkg::BYTE_W-1:0]  out_byte,
  output logic [lscc_pkg::CK_W-1:0]    out_checksum,
  output logic                         out_tampered,
  output logic                         out_end_of_block
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [lscc_pkg::SEED_W-1:0] seed_r;
  logic                        dec_r;

  // --------------------------------------------------------------------------
  // input stage
  // --------------------------------------------------------------------------
  logic                        s1_valid_r;
  logic [lscc_pkg::BYTE_W-1:0] s1_data_r;
  logic                        s1_first_r;
  logic                        s1_last_r;
  logic [lscc_pkg::CK_W-1:0]   s1_expected_r;

  // cipher state: generator and checksum accumulator
  logic [lscc_pkg::SEED_W-1:0] lcg_r;
  logic [lscc_pkg::SEED_W-1:0] lcg_nxt;
  logic [lscc_pkg::CK_W-1:0]   sum_r;
  logic [lscc_pkg::CK_W-1:0]   sum_nxt;

  // result register
  logic                        out_valid_r;
  logic [lscc_pkg::BYTE_W-1:0] out_byte_r;
  logic [lscc_pkg::CK_W-1:0]   out_checksum_r;
  logic                        out_tampered_r;
  logic                        out_eob_r;

  logic adv;       // input stage moves into the result register
  logic in_take;   // new request into the input stage

  assign adv      = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | adv;
  assign in_take  = in_valid & in_ready;

  // --------------------------------------------------------------------------
  // datapath: one generator step and one checksum fold
  // --------------------------------------------------------------------------
  logic [lscc_pkg::SEED_W-1:0]   gen_in;
  logic [lscc_pkg::KS_SUM_W-1:0] ks_sum;
  logic [lscc_pkg::BYTE_W-1:0]   key_byte;
  logic [lscc_pkg::BYTE_W-1:0]   cipher_byte;
  logic [lscc_pkg::BYTE_W-1:0]   fold_byte;
  logic [lscc_pkg::CK_W-1:0]     acc_in;
  logic [lscc_pkg::CK_SUM_W-1:0] ck_part;
  logic [lscc_pkg::CK_SUM_W-1:0] ck_total;
  logic                          tamper_nxt;

  always_comb begin
    // first byte of a block restarts from the seed register and the init sum
    gen_in = s1_first_r ? seed_r : lcg_r;
    acc_in = s1_first_r ? lscc_pkg::CK_W'(lscc_pkg::CK_INIT) : sum_r;

    // seed*2399 mod M as a sum of per-digit residues, plus the offset
    ks_sum = lscc_pkg::KS_SUM_W'(lscc_pkg::KS_OFFSET);
    for (int k = 0; k < lscc_pkg::KS_DIGITS; k++) begin
      ks_sum = ks_sum + lscc_pkg::KS_SUM_W'(
        lscc_pkg::KS_TAB[k][gen_in[k*lscc_pkg::DIG_W +: lscc_pkg::DIG_W]]);
    end
    lcg_nxt = lscc_pkg::ks_reduce(ks_sum);

    key_byte    = lcg_nxt[17:10];
    cipher_byte = s1_data_r ^ key_byte;
    fold_byte   = dec_r ? cipher_byte : s1_data_r;

    // (sum<<8) mod C from digit residues; the top digit is only 3 bits wide
    ck_part = '0;
    for (int k = 0; k < lscc_pkg::CK_DIGITS - 1; k++) begin
      ck_part = ck_part + lscc_pkg::CK_SUM_W'(
        lscc_pkg::CK_TAB[k][acc_in[k*lscc_pkg::DIG_W +: lscc_pkg::DIG_W]]);
    end
    ck_part = ck_part + lscc_pkg::CK_SUM_W'(
      lscc_pkg::CK_TAB[lscc_pkg::CK_DIGITS-1][{2'b00, acc_in[lscc_pkg::CK_W-1:20]}]);

    // byte joins last so the keystream path only meets one adder here
    ck_total = ck_part + lscc_pkg::CK_SUM_W'(fold_byte);
    sum_nxt  = lscc_pkg::ck_reduce(ck_total);

    tamper_nxt = s1_last_r & dec_r & (sum_nxt != s1_expected_r);
  end

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      dec_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lcg_r       <= '0;
      sum_r       <= lscc_pkg::CK_W'(lscc_pkg::CK_INIT);
    end else begin
      if (cfg_wr_en) begin
        unique case (lscc_pkg::cfg_idx_t'(cfg_index))
          lscc_pkg::CFG_SEED_START:   seed_r <= cfg_wdata;
          lscc_pkg::CFG_DECRYPT_MODE: dec_r  <= cfg_wdata[0];
        endcase
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        lcg_r       <= lcg_nxt;
        sum_r       <= sum_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r     <= in_data_byte;
      s1_first_r    <= in_first;
      s1_last_r     <= in_last;
      s1_expected_r <= in_expected_checksum;
    end
    if (adv) begin
      out_byte_r     <= cipher_byte;
      out_checksum_r <= sum_nxt;
      out_tampered_r <= tamper_nxt;
      out_eob_r      <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_checksum     = out_checksum_r;
  assign out_tampered     = out_tampered_r;
  assign out_end_of_block = out_eob_r;

`ifndef SYNTHESIS
  // generator never leaves its modulus range
  a_lcg_range: assert property (@(posedge clk) disable iff (!rst_n)
    64'(lcg_r) < lscc_pkg::KS_MOD)
    else $error("generator state out of range");

  // checksum accumulator never leaves its modulus range
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    64'(sum_r) < lscc_pkg::CK_MOD)
    else $error("checksum state out of range");

  // tamper only on a last byte while decrypting
  a_tamper_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tampered_r |-> out_eob_r && dec_r)
    else $error("tamper flag outside decrypt last byte");

  // a stage move always lands a result
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced request lost");

  // an empty input stage always takes a request
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("ready low with empty input stage");
`endif

endmodule
